// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DVP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DVP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dvp_pkg.sv =====
// ----------------------------------------------------------------------------
// dvp_pkg
// Shared types and constants of the DV DIF block placer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dvp_pkg;

  localparam int unsigned OFF_W       = 19;     // raw offset, before bounds check
  localparam int unsigned CNT_W       = 12;
  localparam int unsigned SEQ_W       = 4;
  localparam int unsigned BLK_W       = 8;
  localparam int unsigned VBLK_W      = 12;     // video block index in the frame

  localparam int unsigned BLOCK_BYTES = 80;
  localparam int unsigned SEQ_BYTES   = 12000;
  localparam int unsigned AUDIO_BASE  = 480;
  localparam int unsigned AUDIO_STEP  = 1280;   // 16 blocks from one audio block to the next
  localparam int unsigned VID_SEQ_BLK = 150;
  localparam int unsigned VID_BASE    = 7;
  localparam int unsigned DIV15_MUL   = 137;    // v*137 >> 11 == v/15 for v < 256
  localparam int unsigned DIV15_SHIFT = 11;

  typedef enum logic [2:0] {
    SECT_HEADER  = 3'd0,
    SECT_SUBCODE = 3'd1,
    SECT_VAUX    = 3'd2,
    SECT_AUDIO   = 3'd3,
    SECT_VIDEO   = 3'd4
  } sect_t;

  typedef enum logic [1:0] {
    ST_PLACED = 2'd0,
    ST_BADSCT = 2'd1,
    ST_BEYOND = 2'd2,
    ST_MARKER = 2'd3
  } status_t;

  // placement decision handed to the flag/count keeper
  typedef struct packed {
    logic             placed;
    logic             hdr;
    logic             vaux;
    logic [SEQ_W-1:0] seq;
  } place_t;

  function automatic logic [4:0] div15(input logic [BLK_W-1:0] v);
    logic [15:0] p;
    p = 16'(v) * 16'(DIV15_MUL);
    return p[15:DIV15_SHIFT];
  endfunction

endpackage

// ===== sv/dvp_offset.sv =====
// ----------------------------------------------------------------------------
// dvp_offset
// Frame store offset per section type, section and bounds check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dvp_offset #(
  parameter int unsigned FRAME_BYTES = 144000
) (
  input  logic [2:0]                   sect,
  input  logic [dvp_pkg::SEQ_W-1:0]    seq,
  input  logic [dvp_pkg::BLK_W-1:0]    blk,
  output dvp_pkg::status_t             status,
  output logic [17:0]                  byte_offset,
  output dvp_pkg::place_t              place
);

  localparam int unsigned OW = dvp_pkg::OFF_W;

  logic [OW-1:0]                 seq_base;
  logic [dvp_pkg::VBLK_W-1:0]    vblk;
  logic [OW-1:0]                 off;
  logic                          sect_ok;
  logic [OW:0]                   end_byte;
  logic                          fits;

  assign seq_base = OW'(seq) * OW'(dvp_pkg::SEQ_BYTES);
  assign vblk = dvp_pkg::VBLK_W'(seq) * dvp_pkg::VBLK_W'(dvp_pkg::VID_SEQ_BLK)
              + dvp_pkg::VBLK_W'(dvp_pkg::VID_BASE) + dvp_pkg::VBLK_W'(blk)
              + dvp_pkg::VBLK_W'(dvp_pkg::div15(blk));

  always_comb begin
    sect_ok = 1'b1;
    unique case (sect)
      dvp_pkg::SECT_HEADER:  off = seq_base;
      dvp_pkg::SECT_SUBCODE: off = seq_base
                                 + (OW'(blk) + OW'(1)) * OW'(dvp_pkg::BLOCK_BYTES);
      dvp_pkg::SECT_VAUX:    off = seq_base
                                 + (OW'(blk) + OW'(3)) * OW'(dvp_pkg::BLOCK_BYTES);
      dvp_pkg::SECT_AUDIO:   off = seq_base + OW'(dvp_pkg::AUDIO_BASE)
                                 + OW'(blk) * OW'(dvp_pkg::AUDIO_STEP);
      dvp_pkg::SECT_VIDEO:   off = OW'(vblk) * OW'(dvp_pkg::BLOCK_BYTES);
      default: begin
        off     = '0;
        sect_ok = 1'b0;
      end
    endcase
  end

  assign end_byte = (OW+1)'(off) + (OW+1)'(dvp_pkg::BLOCK_BYTES);
  assign fits     = (end_byte <= (OW+1)'(FRAME_BYTES));

  always_comb begin
    if (!sect_ok) begin
      status = dvp_pkg::ST_BADSCT;
    end else if (!fits) begin
      status = dvp_pkg::ST_BEYOND;
    end else begin
      status = dvp_pkg::ST_PLACED;
    end
  end

  assign place.placed = sect_ok && fits;
  assign place.hdr    = (sect == dvp_pkg::SECT_HEADER);
  assign place.vaux   = (sect == dvp_pkg::SECT_VAUX);
  assign place.seq    = seq;
  assign byte_offset  = place.placed ? off[17:0] : 18'd0;

endmodule

// ===== sv/dvp_track.sv =====
// ----------------------------------------------------------------------------
// dvp_track
// Per-sequence header/VAUX seen flags, sticky readiness and block counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dvp_track #(
  parameter int unsigned SEQ_FLAGS   = 12,
  parameter int unsigned SEQ_CHECKED = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,     // item leaves the input stage
  input  logic                         marker,
  input  dvp_pkg::place_t              place,
  output logic                         frame_ready,
  output logic [dvp_pkg::CNT_W-1:0]    blocks_stored
);

  logic [SEQ_FLAGS-1:0]         hdr_seen_r,  hdr_seen_nxt;
  logic [SEQ_FLAGS-1:0]         vaux_seen_r, vaux_seen_nxt;
  logic                         hc_r,        hc_nxt;
  logic [dvp_pkg::CNT_W-1:0]    count_r,     count_nxt;
  logic                         all_seen;

  generate
    if (SEQ_CHECKED > SEQ_FLAGS) begin : g_short
      // checked sequences without a flag never count as seen
      assign all_seen = 1'b0;
    end else begin : g_check
      assign all_seen = &(hdr_seen_r[SEQ_CHECKED-1:0] & vaux_seen_r[SEQ_CHECKED-1:0]);
    end
  endgenerate

  assign frame_ready   = hc_r | all_seen;
  assign blocks_stored = count_r;

  always_comb begin
    hdr_seen_nxt  = hdr_seen_r;
    vaux_seen_nxt = vaux_seen_r;
    hc_nxt        = hc_r;
    count_nxt     = count_r;
    if (step) begin
      if (marker) begin
        hc_nxt    = frame_ready;
        count_nxt = '0;
      end else if (place.placed) begin
        for (int s = 0; s < SEQ_FLAGS; s++) begin
          if (place.seq == dvp_pkg::SEQ_W'(s)) begin
            if (place.hdr) hdr_seen_nxt[s] = 1'b1;
            if (place.vaux) vaux_seen_nxt[s] = 1'b1;
          end
        end
        if (count_r != '1) count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_seen_r  <= '0;
      vaux_seen_r <= '0;
      hc_r        <= 1'b0;
      count_r     <= '0;
    end else begin
      hdr_seen_r  <= hdr_seen_nxt;
      vaux_seen_r <= vaux_seen_nxt;
      hc_r        <= hc_nxt;
      count_r     <= count_nxt;
    end
  end

endmodule

// ===== sv/dv_dif_block_placer.sv =====
// ----------------------------------------------------------------------------
// dv_dif_block_placer
// Places DV DIF blocks in a frame store and reports frame readiness.
//
// in_*  : one word per DIF block ID (in_tuser = 0) or per packet end with
//         marker (in_tuser = 1). Block words give back the byte offset of the
//         80-byte block, or a reject status for an unknown section type or
//         a block past the end of the frame.
// out_* : one result word per input word, in order; out_tuser is the status.
// A marker returns frame_ready (all header and VAUX blocks of the checked
// sequences seen, sticky) and the count of blocks placed since the last
// marker, then clears that count.
// A word passes the input register, then the result register; one word is taken
// per cycle sustained while the receiver does not stall the result register.
// A stalled receiver holds the result; one more word is still taken into the
// input register, after which in_tready drops.
// Reset clears all seen flags, readiness, the counter and both valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dv_dif_block_placer #(
  parameter int unsigned FRAME_BYTES = 144000,
  parameter int unsigned SEQ_FLAGS   = 12,
  parameter int unsigned SEQ_CHECKED = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // section_type[2:0], sequence_number[6:3],
                                  // block_number[14:7], zero pad[15]
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // byte_offset[17:0], frame_ready[18],
                                  // blocks_stored[30:19], zero pad[31]
  output logic [1:0]  out_tuser   // status
);

  logic                             s1_valid_r, s1_valid_nxt;
  logic                             s1_req_r;
  logic [2:0]                       s1_sect_r;
  logic [dvp_pkg::SEQ_W-1:0]        s1_seq_r;
  logic [dvp_pkg::BLK_W-1:0]        s1_blk_r;
  logic                             out_valid_r, out_valid_nxt;
  logic [31:0]                      out_data_r,  out_data_nxt;
  logic [1:0]                       out_user_r,  out_user_nxt;
  logic                             in_fire;
  logic                             s1_adv;

  dvp_pkg::status_t                 blk_status;
  logic [17:0]                      blk_offset;
  dvp_pkg::place_t                  place;
  logic                             frame_ready;
  logic [dvp_pkg::CNT_W-1:0]        blocks_stored;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  dvp_offset #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_offset (
    .sect        (s1_sect_r),
    .seq         (s1_seq_r),
    .blk         (s1_blk_r),
    .status      (blk_status),
    .byte_offset (blk_offset),
    .place       (place)
  );

  dvp_track #(
    .SEQ_FLAGS   (SEQ_FLAGS),
    .SEQ_CHECKED (SEQ_CHECKED)
  ) u_track (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (s1_adv),
    .marker        (s1_req_r),
    .place         (place),
    .frame_ready   (frame_ready),
    .blocks_stored (blocks_stored)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      if (s1_req_r) begin
        out_user_nxt = dvp_pkg::ST_MARKER;
        out_data_nxt = {1'b0, blocks_stored, frame_ready, 18'd0};
      end else begin
        out_user_nxt = blk_status;
        out_data_nxt = {14'd0, blk_offset};
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r  <= in_tuser;
      s1_sect_r <= in_tdata[2:0];
      s1_seq_r  <= in_tdata[6:3];
      s1_blk_r  <= in_tdata[14:7];
    end
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `DVP_ASSERT_IMP(a_idle_takes, clk, rst_n, !s1_valid_r, in_tready,
    "empty input stage must take a word")
  `DVP_ASSERT_NXT(a_marker_clears, clk, rst_n, s1_adv && s1_req_r,
    blocks_stored == '0, "marker must clear the block count")
  `DVP_ASSERT_NXT(a_ready_sticky, clk, rst_n, frame_ready, frame_ready,
    "frame readiness must not drop")
  `DVP_ASSERT_IMP(a_block_fields, clk, rst_n,
    out_valid_r && (out_user_r != dvp_pkg::ST_MARKER), out_data_r[31:18] == '0,
    "block result carries marker fields")

endmodule

// ===== test/dv_dif_block_placer_tb.sv =====
// ----------------------------------------------------------------------------
// dv_dif_block_placer_tb
// Self-checking bench for the DV DIF block placer.
//
// A driver feeds DIF block ID words and marker words from a pending queue,
// with random gaps. Every accepted word goes through a local placement
// predictor (offsets, seen flags, sticky readiness, saturating count). The
// expected result is queued. A monitor, with its own random stalls and one
// long hold-off, compares every result word field by field with the oldest
// expected one. Stimulus: directed corner blocks, random frames of blocks
// closed by markers, then a long run of video blocks without a marker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dv_dif_block_placer_tb;

  localparam int unsigned FRAME_BYTES = 144000;
  localparam int unsigned SEQ_FLAGS   = 12;
  localparam int unsigned SEQ_CHECKED = 10;
  localparam int unsigned RAND_ITEMS  = 1400;
  localparam int unsigned RUN_BLOCKS  = 400;
  localparam int unsigned IDLE_LIMIT  = 5000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [11:0] CNT_MAX     = 12'hfff;

  typedef struct {
    logic       req;
    logic [2:0] sct;
    logic [3:0] seq;
    logic [7:0] blk;
  } dif_word_t;

  typedef struct {
    dvp_pkg::status_t status;
    logic [17:0]      off;
    logic             ready;
    logic [11:0]      cnt;
  } place_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  dif_word_t  pend_q[$];
  place_res_t place_q[$];

  // predictor state
  bit          hdr_seen[SEQ_FLAGS];
  bit          vaux_seen[SEQ_FLAGS];
  bit          frame_ready_q;
  logic [11:0] placed_cnt;

  int unsigned err_cnt = 0;
  int unsigned res_idx = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_wait = 0;
  int unsigned idle_cycles = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  bit          hold_done = 1'b0;

  dv_dif_block_placer #(
    .FRAME_BYTES(FRAME_BYTES),
    .SEQ_FLAGS  (SEQ_FLAGS),
    .SEQ_CHECKED(SEQ_CHECKED)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic place_res_t place_block(dif_word_t w);
    place_res_t  r;
    int unsigned off;
    int unsigned base;
    bit          known;
    bit          all_seen;
    r.status = dvp_pkg::ST_PLACED;
    r.off    = '0;
    r.ready  = 1'b0;
    r.cnt    = '0;
    if (w.req) begin
      if (!frame_ready_q) begin
        all_seen = 1'b1;
        for (int unsigned s = 0; s < SEQ_CHECKED; s++) begin
          if (s >= SEQ_FLAGS) all_seen = 1'b0;
          else if (!hdr_seen[s] || !vaux_seen[s]) all_seen = 1'b0;
        end
        if (all_seen) frame_ready_q = 1'b1;
      end
      r.status   = dvp_pkg::ST_MARKER;
      r.ready    = frame_ready_q;
      r.cnt      = placed_cnt;
      placed_cnt = '0;
      return r;
    end
    base  = int'(w.seq) * dvp_pkg::SEQ_BYTES;
    known = 1'b1;
    off   = 0;
    case (w.sct)
      dvp_pkg::SECT_HEADER:  off = base;
      dvp_pkg::SECT_SUBCODE: off = base + (int'(w.blk) + 1) * dvp_pkg::BLOCK_BYTES;
      dvp_pkg::SECT_VAUX:    off = base + (int'(w.blk) + 3) * dvp_pkg::BLOCK_BYTES;
      dvp_pkg::SECT_AUDIO:   off = base + dvp_pkg::AUDIO_BASE
                                   + int'(w.blk) * dvp_pkg::AUDIO_STEP;
      dvp_pkg::SECT_VIDEO:   off = (int'(w.seq) * dvp_pkg::VID_SEQ_BLK + dvp_pkg::VID_BASE
                                    + int'(w.blk) + int'(w.blk) / 15)
                                   * dvp_pkg::BLOCK_BYTES;
      default:               known = 1'b0;
    endcase
    if (!known) begin
      r.status = dvp_pkg::ST_BADSCT;
      return r;
    end
    if (off + dvp_pkg::BLOCK_BYTES > FRAME_BYTES) begin
      r.status = dvp_pkg::ST_BEYOND;
      return r;
    end
    if (w.seq < SEQ_FLAGS) begin
      if (w.sct == dvp_pkg::SECT_HEADER) hdr_seen[w.seq] = 1'b1;
      else if (w.sct == dvp_pkg::SECT_VAUX) vaux_seen[w.seq] = 1'b1;
    end
    if (placed_cnt != CNT_MAX) placed_cnt = placed_cnt + 1'b1;
    r.off = off[17:0];
    return r;
  endfunction

  // mostly short gaps, a few long, with stretches of none at all
  function automatic int unsigned pick_gap(inout bit steady);
    int unsigned r;
    if ($urandom_range(0, 99) == 0) steady = ~steady;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_word(input logic req, input logic [2:0] sct, input logic [3:0] seq,
                          input logic [7:0] blk);
    dif_word_t w;
    w.req = req;
    w.sct = sct;
    w.seq = seq;
    w.blk = blk;
    pend_q.push_back(w);
  endtask

  task automatic add_random_block(input bit early);
    logic [2:0] sct;
    logic [3:0] seq;
    logic [7:0] blk;
    if ($urandom_range(0, 99) < 85) begin
      sct = 3'($urandom_range(0, 4));
      seq = 4'($urandom_range(0, 11));
      case (sct)
        dvp_pkg::SECT_HEADER:  blk = 8'd0;
        dvp_pkg::SECT_SUBCODE: blk = 8'($urandom_range(0, 1));
        dvp_pkg::SECT_VAUX:    blk = 8'($urandom_range(0, 2));
        dvp_pkg::SECT_AUDIO:   blk = 8'($urandom_range(0, 8));
        default:               blk = 8'($urandom_range(0, 134));
      endcase
      // hold back one VAUX flag for a while so readiness stays just short
      if (early && sct == dvp_pkg::SECT_VAUX && seq == 4'd9) seq = 4'd10;
    end else begin
      sct = 3'($urandom);
      seq = 4'($urandom);
      blk = 8'($urandom);
    end
    add_word(1'b0, sct, seq, blk);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH word %0d: %s got %0d expected %0d", res_idx, what, got, want);
    err_cnt++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) place_q.push_back(place_block(pend_q.pop_front()));
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tuser  <= pend_q[0].req;
          in_tdata  <= {1'b0, pend_q[0].blk, pend_q[0].seq, pend_q[0].sct};
          tx_gap    = pick_gap(tx_steady);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    place_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (place_q.size() == 0) begin
          report_mismatch("unexpected word, status", out_tuser, 0);
        end else begin
          want = place_q.pop_front();
          if (out_tuser != want.status) report_mismatch("status", out_tuser, want.status);
          if (out_tdata[17:0] != want.off)
            report_mismatch("byte_offset", out_tdata[17:0], want.off);
          if (out_tdata[18] != want.ready)
            report_mismatch("frame_ready", out_tdata[18], want.ready);
          if (out_tdata[30:19] != want.cnt)
            report_mismatch("blocks_stored", out_tdata[30:19], want.cnt);
        end
        res_idx++;
        rx_wait = pick_gap(rx_steady);
        // one long hold-off so the block backs up into its input
        if (!hold_done && res_idx == 400) begin
          hold_done = 1'b1;
          rx_wait   = HOLD_CYCLES;
        end
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog: no word moving on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned blocks;
    for (int s = 0; s < SEQ_FLAGS; s++) begin
      hdr_seen[s]  = 1'b0;
      vaux_seen[s] = 1'b0;
    end
    frame_ready_q = 1'b0;
    placed_cnt    = '0;

    // directed corners
    add_word(1'b1, 3'($urandom), 4'($urandom), 8'($urandom));  // marker on empty state
    add_word(1'b0, dvp_pkg::SECT_HEADER,  4'd0,  8'd0);
    add_word(1'b0, dvp_pkg::SECT_HEADER,  4'd15, 8'd255);
    add_word(1'b0, dvp_pkg::SECT_HEADER,  4'd12, 8'd0);    // starts exactly at the frame end
    add_word(1'b0, dvp_pkg::SECT_HEADER,  4'd11, 8'd0);
    add_word(1'b0, dvp_pkg::SECT_SUBCODE, 4'd0,  8'd0);
    add_word(1'b0, dvp_pkg::SECT_SUBCODE, 4'd11, 8'd255);
    add_word(1'b0, dvp_pkg::SECT_VAUX,    4'd0,  8'd255);
    add_word(1'b0, dvp_pkg::SECT_VAUX,    4'd11, 8'd0);
    add_word(1'b0, dvp_pkg::SECT_AUDIO,   4'd0,  8'd8);
    add_word(1'b0, dvp_pkg::SECT_AUDIO,   4'd11, 8'd8);
    add_word(1'b0, dvp_pkg::SECT_AUDIO,   4'd11, 8'd9);
    add_word(1'b0, dvp_pkg::SECT_AUDIO,   4'd0,  8'd255);
    add_word(1'b0, dvp_pkg::SECT_VIDEO,   4'd0,  8'd0);
    add_word(1'b0, dvp_pkg::SECT_VIDEO,   4'd11, 8'd134);  // last block that fits
    add_word(1'b0, dvp_pkg::SECT_VIDEO,   4'd11, 8'd135);
    add_word(1'b0, dvp_pkg::SECT_VIDEO,   4'd15, 8'd255);
    add_word(1'b0, 3'd5,                  4'd0,  8'd0);
    add_word(1'b0, 3'd6,                  4'd3,  8'd17);
    add_word(1'b0, 3'd7,                  4'd15, 8'd255);
    add_word(1'b1, 3'd7,                  4'd15, 8'd255);
    add_word(1'b1, 3'd0,                  4'd0,  8'd0);    // back-to-back marker, count cleared

    // random frames: blocks closed by a marker
    n = 0;
    while (n < RAND_ITEMS) begin
      blocks = $urandom_range(0, 40);
      for (int unsigned b = 0; b < blocks; b++) add_random_block(n < RAND_ITEMS / 3);
      add_word(1'b1, 3'($urandom), 4'($urandom), 8'($urandom));
      n += blocks + 1;
    end

    // long run of video blocks without a marker
    for (int unsigned b = 0; b < RUN_BLOCKS; b++)
      add_word(1'b0, dvp_pkg::SECT_VIDEO, 4'($urandom_range(0, 10)),
               8'($urandom_range(0, 134)));
    add_word(1'b1, 3'($urandom), 4'($urandom), 8'($urandom));
    for (int unsigned b = 0; b < 5; b++) add_random_block(1'b0);
    add_word(1'b1, 3'($urandom), 4'($urandom), 8'($urandom));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (pend_q.size() != 0) @(posedge clk);
    while (place_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
